FILE: rtl/utf8_console_line_editor_assert.svh
// Assertion macros for the console line editor.
// Expects signals named clock and reset in the scope of each use.
`ifndef UTF8_CONSOLE_LINE_EDITOR_ASSERT_SVH
`define UTF8_CONSOLE_LINE_EDITOR_ASSERT_SVH

// same-cycle implication
`define UCLE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UCLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ucle_pkg.sv
// Shared types, constants and ring index helpers for the console line editor.
// No dependencies.
package ucle_pkg;

   localparam int unsigned RING_DEPTH = 128;
   localparam int unsigned ADDR_W     = $clog2(RING_DEPTH);
   localparam int unsigned IDX_MOD    = 2 * RING_DEPTH;
   localparam int unsigned IDX_W      = $clog2(IDX_MOD);

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [ADDR_W-1:0] addr_type;

   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CTRL_D    = 8'h04;
   localparam logic [7:0] CTRL_H    = 8'h08;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CTRL_P    = 8'h10;
   localparam logic [7:0] CTRL_U    = 8'h15;
   localparam logic [7:0] DEL_KEY   = 8'h7F;
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;

   localparam logic [8:0] COL_MAX  = 9'd511;
   // character length counter saturates here: anything longer decodes as its lead byte
   localparam logic [2:0] LEN_OVER = 3'd5;

   typedef enum logic {
      CMD_RX  = 1'b0,
      CMD_POP = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ECHO  = 3'd0,
      KIND_ERASE = 3'd1,
      KIND_DATA  = 3'd2,
      KIND_EMPTY = 3'd3,
      KIND_EOF   = 3'd4
   } kind_type;

   typedef logic [20:0] rune_type;

   localparam int unsigned WIDE_RANGES = 10;
   localparam rune_type WIDE_LO [WIDE_RANGES] = '{
      21'h01100, 21'h02329, 21'h02E80, 21'h0AC00, 21'h0F900,
      21'h0FE10, 21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h20000
   };
   localparam rune_type WIDE_HI [WIDE_RANGES] = '{
      21'h0115F, 21'h0232A, 21'h0A4CF, 21'h0D7A3, 21'h0FAFF,
      21'h0FE19, 21'h0FE6F, 21'h0FF60, 21'h0FFE6, 21'h3FFFD
   };

   // lead byte, byte count, and continuation payload (nearest-to-cursor byte in bits 5:0)
   typedef struct packed {
      logic [7:0]  c0;
      logic [2:0]  len;
      logic [17:0] acc;
   } rune_parts_type;

   function automatic idx_type idx_inc(idx_type a);
      return (a == idx_type'(IDX_MOD - 1)) ? '0 : a + idx_type'(1);
   endfunction

   function automatic idx_type idx_dec(idx_type a);
      return (a == '0) ? idx_type'(IDX_MOD - 1) : a - idx_type'(1);
   endfunction

   function automatic idx_type idx_sub(idx_type a, idx_type b);
      logic [IDX_W:0] t;
      t = {1'b0, a} + (IDX_W+1)'(IDX_MOD) - {1'b0, b};
      return (a >= b) ? a - b : idx_type'(t);
   endfunction

   function automatic addr_type idx_addr(idx_type a);
      return (a >= idx_type'(RING_DEPTH)) ? addr_type'(a - idx_type'(RING_DEPTH))
                                          : addr_type'(a);
   endfunction

endpackage

FILE: rtl/ucle_channels.sv
// Request and response channel interfaces of the console line editor.
// Valid/ready handshake; a word moves when both are high. No dependencies.
interface ucle_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_char;
   logic       mid_read;

   modport source (output valid, cmd, rx_char, mid_read, input ready);
   modport sink   (input valid, cmd, rx_char, mid_read, output ready);
endinterface

interface ucle_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] out_byte;
   logic [8:0] erase_columns;
   logic       line_end;

   modport source (output valid, kind, out_byte, erase_columns, line_end, input ready);
   modport sink   (input valid, kind, out_byte, erase_columns, line_end, output ready);
endinterface

FILE: rtl/utf8_console_line_editor.sv
// Canonical-mode console line editor: ring store, index registers and sequencer.
// Depends on ucle_pkg, ucle_channels, ucle_ram, ucle_rune_width and the assert header.

// A keyboard byte (cmd 0) but NUL, ^P or an erase key is stored and echoed while the
// ring has room, CR turned into LF; LF, ^D or a full ring commits the line. A pop
// (cmd 1) is answered from S_IDLE if no committed byte waits, else via S_RDATA.
// Backspace/DEL pass S_ERASE_GO, S_WALK, S_WIDTH; ^U loops S_KILL_CHK, S_KILL_TEST,
// S_WALK, S_WIDTH per character. The ring has a single registered read port: the erase
// walks back over continuation bytes one byte per cycle, then does the width lookup.
// The ring needs no clearing pass after reset. req_chan.ready is low while an item is
// being worked, and also while a result waits with rsp_chan.ready low.
`include "utf8_console_line_editor_assert.svh"

module utf8_console_line_editor (
   input  logic       clock,
   input  logic       reset,
   ucle_req_if.sink   req_chan,
   ucle_rsp_if.source rsp_chan
);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_RDATA     = 7'b0000010,
      S_ERASE_GO  = 7'b0000100,
      S_KILL_CHK  = 7'b0001000,
      S_KILL_TEST = 7'b0010000,
      S_WALK      = 7'b0100000,
      S_WIDTH     = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   ucle_pkg::idx_type        read_ff, read_in;
   ucle_pkg::idx_type        commit_ff, commit_in;
   ucle_pkg::idx_type        edit_ff, edit_in;
   ucle_pkg::idx_type        walk_ff, walk_in;
   logic [2:0]               len_ff, len_in;
   logic [17:0]              acc_ff, acc_in;
   logic [7:0]               c0_ff, c0_in;
   logic [8:0]               cols_ff, cols_in;
   logic                     kill_ff, kill_in;
   logic                     mid_ff, mid_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   ucle_pkg::kind_type       rsp_kind_ff, rsp_kind_in;
   logic [7:0]               rsp_byte_ff, rsp_byte_in;
   logic [8:0]               rsp_cols_ff, rsp_cols_in;
   logic                     rsp_end_ff, rsp_end_in;

   logic                     req_fire;
   logic                     load;
   ucle_pkg::kind_type       load_kind;
   logic [7:0]               load_byte;
   logic [8:0]               load_cols;
   logic                     load_end;

   logic                     ram_we;
   ucle_pkg::addr_type       ram_waddr;
   ucle_pkg::addr_type       ram_raddr;
   logic [7:0]               ram_wdata;
   logic [7:0]               ram_rdata;

   ucle_pkg::idx_type        used;
   ucle_pkg::idx_type        edit_m1;
   ucle_pkg::idx_type        walk_m1;
   logic [7:0]               rx_mapped;
   ucle_pkg::rune_parts_type parts;
   logic                     wide;
   logic [9:0]               cols_sum;
   logic [8:0]               cols_sat;

   logic                     chk_occ_ok;
   logic                     chk_order_ok;
   logic                     chk_empty_pop;
   logic                     chk_empty_ans;
   logic                     chk_slot_free;
   logic                     chk_len_ok;

   ucle_ram #(
      .WIDTH (8),
      .DEPTH (ucle_pkg::RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign parts = '{c0: c0_ff, len: len_ff, acc: acc_ff};

   ucle_rune_width u_width (
      .parts (parts),
      .wide  (wide)
   );

   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign used      = ucle_pkg::idx_sub(edit_ff, read_ff);
   assign edit_m1   = ucle_pkg::idx_dec(edit_ff);
   assign walk_m1   = ucle_pkg::idx_dec(walk_ff);
   assign rx_mapped = (req_chan.rx_char == ucle_pkg::CHAR_CR) ? ucle_pkg::CHAR_LF
                                                              : req_chan.rx_char;
   assign cols_sum  = {1'b0, cols_ff} + (wide ? 10'd2 : 10'd1);
   assign cols_sat  = (cols_sum > {1'b0, ucle_pkg::COL_MAX}) ? ucle_pkg::COL_MAX
                                                             : cols_sum[8:0];

   always_comb begin
      state_in  = state_ff;
      read_in   = read_ff;
      commit_in = commit_ff;
      edit_in   = edit_ff;
      walk_in   = walk_ff;
      len_in    = len_ff;
      acc_in    = acc_ff;
      c0_in     = c0_ff;
      cols_in   = cols_ff;
      kill_in   = kill_ff;
      mid_in    = mid_ff;

      ram_we    = 1'b0;
      ram_waddr = ucle_pkg::idx_addr(edit_ff);
      ram_wdata = rx_mapped;
      ram_raddr = ucle_pkg::idx_addr(read_ff);

      load      = 1'b0;
      load_kind = ucle_pkg::KIND_ECHO;
      load_byte = 8'd0;
      load_cols = 9'd0;
      load_end  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.cmd == ucle_pkg::CMD_POP) begin
                  mid_in = req_chan.mid_read;
                  if (read_ff == commit_ff) begin
                     load      = 1'b1;
                     load_kind = ucle_pkg::KIND_EMPTY;
                  end else begin
                     state_in = S_RDATA;
                  end
               end else begin
                  case (req_chan.rx_char) inside
                     ucle_pkg::CTRL_P: begin
                     end
                     ucle_pkg::CTRL_U: begin
                        cols_in  = 9'd0;
                        kill_in  = 1'b1;
                        state_in = S_KILL_CHK;
                     end
                     ucle_pkg::CTRL_H, ucle_pkg::DEL_KEY: begin
                        if (edit_ff != commit_ff) begin
                           cols_in  = 9'd0;
                           kill_in  = 1'b0;
                           state_in = S_ERASE_GO;
                        end
                     end
                     default: begin
                        if ((req_chan.rx_char != ucle_pkg::CHAR_NUL) &&
                            (used < ucle_pkg::idx_type'(ucle_pkg::RING_DEPTH))) begin
                           ram_we  = 1'b1;
                           edit_in = ucle_pkg::idx_inc(edit_ff);
                           if ((rx_mapped == ucle_pkg::CHAR_LF) ||
                               (rx_mapped == ucle_pkg::CTRL_D) ||
                               (used == ucle_pkg::idx_type'(ucle_pkg::RING_DEPTH - 1))) begin
                              commit_in = ucle_pkg::idx_inc(edit_ff);
                           end
                           load      = 1'b1;
                           load_kind = ucle_pkg::KIND_ECHO;
                           load_byte = rx_mapped;
                        end
                     end
                  endcase
               end
            end
         end

         S_RDATA: begin
            state_in = S_IDLE;
            load     = 1'b1;
            if (ram_rdata == ucle_pkg::CTRL_D) begin
               // mid-read: leave ^D in the ring for the next read
               if (!mid_ff) begin
                  read_in = ucle_pkg::idx_inc(read_ff);
               end
               load_kind = ucle_pkg::KIND_EOF;
            end else begin
               read_in   = ucle_pkg::idx_inc(read_ff);
               load_kind = ucle_pkg::KIND_DATA;
               load_byte = ram_rdata;
               load_end  = (ram_rdata == ucle_pkg::CHAR_LF);
            end
         end

         S_ERASE_GO: begin
            ram_raddr = ucle_pkg::idx_addr(edit_m1);
            walk_in   = edit_m1;
            len_in    = 3'd1;
            acc_in    = '0;
            state_in  = S_WALK;
         end

         S_KILL_CHK: begin
            ram_raddr = ucle_pkg::idx_addr(edit_m1);
            if (edit_ff == commit_ff) begin
               state_in  = S_IDLE;
               load      = (cols_ff != 9'd0);
               load_kind = ucle_pkg::KIND_ERASE;
               load_cols = cols_ff;
            end else begin
               state_in = S_KILL_TEST;
            end
         end

         S_KILL_TEST: begin
            // ^U stops at a newline left in the uncommitted part
            ram_raddr = ucle_pkg::idx_addr(edit_m1);
            if (ram_rdata == ucle_pkg::CHAR_LF) begin
               state_in  = S_IDLE;
               load      = (cols_ff != 9'd0);
               load_kind = ucle_pkg::KIND_ERASE;
               load_cols = cols_ff;
            end else begin
               walk_in  = edit_m1;
               len_in   = 3'd1;
               acc_in   = '0;
               state_in = S_WALK;
            end
         end

         S_WALK: begin
            // ram_rdata holds the byte at walk_ff
            ram_raddr = ucle_pkg::idx_addr(walk_m1);
            if ((walk_ff != commit_ff) &&
                ((ram_rdata & ucle_pkg::CONT_MASK) == ucle_pkg::CONT_TAG)) begin
               walk_in = walk_m1;
               len_in  = (len_ff == ucle_pkg::LEN_OVER) ? len_ff : len_ff + 3'd1;
               case (len_ff)
                  3'd1:    acc_in[5:0]   = ram_rdata[5:0];
                  3'd2:    acc_in[11:6]  = ram_rdata[5:0];
                  3'd3:    acc_in[17:12] = ram_rdata[5:0];
                  default: acc_in        = acc_ff;
               endcase
            end else begin
               c0_in    = ram_rdata;
               edit_in  = walk_ff;
               state_in = S_WIDTH;
            end
         end

         S_WIDTH: begin
            if (kill_ff) begin
               cols_in  = cols_sat;
               state_in = S_KILL_CHK;
            end else begin
               load      = 1'b1;
               load_kind = ucle_pkg::KIND_ERASE;
               load_cols = cols_sat;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_cols_in  = rsp_cols_ff;
      rsp_end_in   = rsp_end_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = load_kind;
         rsp_byte_in  = load_byte;
         rsp_cols_in  = load_cols;
         rsp_end_in   = load_end;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         read_ff      <= '0;
         commit_ff    <= '0;
         edit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         read_ff      <= read_in;
         commit_ff    <= commit_in;
         edit_ff      <= edit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff     <= walk_in;
      len_ff      <= len_in;
      acc_ff      <= acc_in;
      c0_ff       <= c0_in;
      cols_ff     <= cols_in;
      kill_ff     <= kill_in;
      mid_ff      <= mid_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_cols_ff <= rsp_cols_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.out_byte      = rsp_byte_ff;
   assign rsp_chan.erase_columns = rsp_cols_ff;
   assign rsp_chan.line_end      = rsp_end_ff;

   assign chk_occ_ok    = (used <= ucle_pkg::idx_type'(ucle_pkg::RING_DEPTH));
   assign chk_order_ok  = (ucle_pkg::idx_sub(commit_ff, read_ff) <= used);
   assign chk_empty_pop = req_fire && (req_chan.cmd == ucle_pkg::CMD_POP) &&
                          (read_ff == commit_ff);
   assign chk_empty_ans = rsp_valid_ff && (rsp_kind_ff == ucle_pkg::KIND_EMPTY);
   assign chk_slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign chk_len_ok    = (len_ff != 3'd0) && (len_ff <= ucle_pkg::LEN_OVER);

   `UCLE_ASSERT_IMP(a_ring_occupancy, 1'b1, chk_occ_ok, "ring holds more than its depth")
   `UCLE_ASSERT_IMP(a_commit_order, 1'b1, chk_order_ok, "commit index beyond edit index")
   `UCLE_ASSERT_NEXT(a_empty_pop, chk_empty_pop, chk_empty_ans, "empty pop not answered")
   `UCLE_ASSERT_IMP(a_slot_free, load, chk_slot_free, "result overwrites a pending word")
   `UCLE_ASSERT_IMP(a_walk_len, state_ff == S_WALK, chk_len_ok, "length counter out of range")

endmodule

FILE: rtl/ucle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ucle_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/ucle_rune_width.sv
// Rebuilds a code point from its UTF-8 pieces and flags double-width runes.
// Depends on ucle_pkg.
module ucle_rune_width (
   input  ucle_pkg::rune_parts_type parts,
   output logic                     wide
);

   always_comb begin
      ucle_pkg::rune_type r;
      logic hit;
      case (parts.len)
         3'd2:    r = {10'd0, parts.c0[4:0], parts.acc[5:0]};
         3'd3:    r = {5'd0, parts.c0[3:0], parts.acc[11:0]};
         3'd4:    r = {parts.c0[2:0], parts.acc[17:0]};
         default: r = {13'd0, parts.c0};
      endcase
      // every range starts above the ASCII block
      hit = 1'b0;
      for (int i = 0; i < ucle_pkg::WIDE_RANGES; i++) begin
         hit = hit | ((r >= ucle_pkg::WIDE_LO[i]) && (r <= ucle_pkg::WIDE_HI[i]));
      end
      wide = hit;
   end

endmodule
